// ===== hw/rtl/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// shared types, codes and pattern tables of the stepper phase sequencer
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int SAMPLE_BITS      = 12;
	localparam int MAX_FOLLOW_STEPS = 63;
	localparam int STEP_BITS        = 6;
	localparam int DIST_SHIFT       = 5;
	localparam int REM_BITS         = SAMPLE_BITS + DIST_SHIFT;
	localparam int DIST_DIVISOR     = 1365;

	localparam logic [3:0] PATTERN_RELEASED = 4'hF;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_OFF     = 3'd1,
		CMD_TOGGLE  = 3'd2,
		CMD_REVERSE = 3'd3,
		CMD_FOLLOW  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_CONT   = 2'd1,
		MODE_FOLLOW = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACT,
		ST_DIR,
		ST_STEP
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} dist_cmd_t;

	typedef struct packed {
		logic ge;
		logic neg;
	} dist_stat_t;

	localparam logic [3:0] HALF_FWD [8] = '{4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9, 4'h8};
	localparam logic [3:0] HALF_REV [8] = '{4'h8, 4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC};
	localparam logic [3:0] FULL_FWD [4] = '{4'hC, 4'h6, 4'h3, 4'h9};
	localparam logic [3:0] FULL_REV [4] = '{4'h9, 4'h3, 4'h6, 4'hC};

	function automatic logic [3:0] half_pattern(input logic fwd, input logic [2:0] idx);
		half_pattern = fwd ? HALF_FWD[idx] : HALF_REV[idx];
	endfunction

	function automatic logic [3:0] full_pattern(input logic fwd, input logic [1:0] idx);
		full_pattern = fwd ? FULL_FWD[idx] : FULL_REV[idx];
	endfunction

endpackage

// ===== hw/rtl/sps_dist_unit.sv =====
// ----------------------------------------------------------------------------
// sps_dist_unit
// shared subtractor: forms the scaled distance, then counts it down by the
// step divisor one step per command
// ----------------------------------------------------------------------------
module sps_dist_unit (
	input  logic                                clk,
	input  sps_pkg::dist_cmd_t                  cmd,
	input  logic [sps_pkg::SAMPLE_BITS-1:0]     sample,
	input  logic [sps_pkg::SAMPLE_BITS-1:0]     old_pos,
	output sps_pkg::dist_stat_t                 stat
);

	logic [sps_pkg::REM_BITS-1:0] rem_q;
	logic                         neg_q;
	logic                         sample_ge;
	logic [sps_pkg::REM_BITS-1:0] op_a;
	logic [sps_pkg::REM_BITS-1:0] op_b;
	logic [sps_pkg::REM_BITS-1:0] diff;

	assign sample_ge = sample >= old_pos;

	// operand select for the one subtractor
	always_comb begin
		if (cmd.load) begin
			op_a = {{sps_pkg::DIST_SHIFT{1'b0}}, (sample_ge ? sample : old_pos)};
			op_b = {{sps_pkg::DIST_SHIFT{1'b0}}, (sample_ge ? old_pos : sample)};
		end else begin
			op_a = rem_q;
			op_b = sps_pkg::REM_BITS'(sps_pkg::DIST_DIVISOR);
		end
	end

	assign diff = op_a - op_b;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= {diff[sps_pkg::SAMPLE_BITS-1:0], {sps_pkg::DIST_SHIFT{1'b0}}};
			neg_q <= !sample_ge;
		end else if (cmd.step) begin
			rem_q <= diff;
		end
	end

	assign stat.ge  = rem_q >= sps_pkg::REM_BITS'(sps_pkg::DIST_DIVISOR);
	assign stat.neg = neg_q;

endmodule

// ===== hw/rtl/stepper_phase_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_core
// tick-driven stepper phase sequencer with off, continuous and follow modes
// ----------------------------------------------------------------------------
// off/continuous ticks: beat formed in ACT, registered once the output slot is free
// follow ticks: ACT loads the distance, DIR sets direction, then STEP gives one beat
//   a cycle while the output is not stalled, up to 64, as the shared unit counts down
// a new tick is taken only in IDLE, after the previous tick's last beat is issued
// reset: off mode, clockwise, phase index 0, old position 0, no beat pending
module stepper_phase_sequencer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick_valid,
	output logic                            tick_ready,
	input  logic [2:0]                      command,
	input  logic [sps_pkg::SAMPLE_BITS-1:0] position_sample,
	output logic                            pattern_valid,
	input  logic                            pattern_ready,
	output logic [3:0]                      phase_pattern,
	output logic                            last
);

	sps_pkg::state_t                 state_q, state_nxt;
	sps_pkg::mode_t                  mode_q;
	logic                            fwd_q;
	logic [2:0]                      idx_q;
	logic [sps_pkg::SAMPLE_BITS-1:0] old_q;
	logic [sps_pkg::SAMPLE_BITS-1:0] sample_q;
	logic [sps_pkg::STEP_BITS-1:0]   count_q;
	logic                            out_valid_q;
	logic [3:0]                      pattern_q;
	logic                            last_q;

	sps_pkg::dist_cmd_t  dcmd;
	sps_pkg::dist_stat_t dstat;

	logic       accept;
	logic       slot_free;
	logic       emit;
	logic [3:0] emit_pattern;
	logic       emit_last;
	logic       more_steps;

	assign accept     = tick_valid && tick_ready;
	assign slot_free  = !out_valid_q || pattern_ready;
	assign more_steps = dstat.ge &&
		(count_q != sps_pkg::STEP_BITS'(sps_pkg::MAX_FOLLOW_STEPS));

	sps_dist_unit u_dist (
		.clk     (clk),
		.cmd     (dcmd),
		.sample  (sample_q),
		.old_pos (old_q),
		.stat    (dstat)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sps_pkg::ST_IDLE: begin
				if (tick_valid) state_nxt = sps_pkg::ST_ACT;
			end
			sps_pkg::ST_ACT: begin
				if (mode_q == sps_pkg::MODE_FOLLOW) state_nxt = sps_pkg::ST_DIR;
				else if (slot_free) state_nxt = sps_pkg::ST_IDLE;
			end
			sps_pkg::ST_DIR: begin
				state_nxt = sps_pkg::ST_STEP;
			end
			sps_pkg::ST_STEP: begin
				if (slot_free && !more_steps) state_nxt = sps_pkg::ST_IDLE;
			end
			default: state_nxt = sps_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		tick_ready   = 1'b0;
		dcmd         = '0;
		emit         = 1'b0;
		emit_pattern = sps_pkg::PATTERN_RELEASED;
		emit_last    = 1'b1;
		unique case (state_q)
			sps_pkg::ST_IDLE: begin
				tick_ready = 1'b1;
			end
			sps_pkg::ST_ACT: begin
				if (mode_q == sps_pkg::MODE_FOLLOW) begin
					dcmd.load = 1'b1;
				end else begin
					emit = slot_free;
					if (mode_q == sps_pkg::MODE_CONT)
						emit_pattern = sps_pkg::full_pattern(fwd_q, idx_q[1:0] + 2'd1);
				end
			end
			sps_pkg::ST_DIR: begin
			end
			sps_pkg::ST_STEP: begin
				emit = slot_free;
				if (more_steps) begin
					dcmd.step    = slot_free;
					emit_pattern = sps_pkg::half_pattern(fwd_q, idx_q + 3'd1);
					emit_last    = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sps_pkg::ST_IDLE;
			mode_q      <= sps_pkg::MODE_OFF;
			fwd_q       <= 1'b1;
			idx_q       <= 3'd0;
			old_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				unique case (sps_pkg::cmd_t'(command))
					sps_pkg::CMD_OFF:     mode_q <= sps_pkg::MODE_OFF;
					sps_pkg::CMD_TOGGLE:  mode_q <= (mode_q == sps_pkg::MODE_CONT) ?
						sps_pkg::MODE_OFF : sps_pkg::MODE_CONT;
					sps_pkg::CMD_REVERSE: fwd_q <= !fwd_q;
					sps_pkg::CMD_FOLLOW: begin
						old_q  <= position_sample;
						mode_q <= sps_pkg::MODE_FOLLOW;
					end
					default: begin
					end
				endcase
			end
			if (state_q == sps_pkg::ST_ACT && emit && mode_q == sps_pkg::MODE_CONT)
				idx_q <= {1'b0, idx_q[1:0] + 2'd1};
			if (state_q == sps_pkg::ST_DIR) begin
				fwd_q   <= !(dstat.neg && dstat.ge);
				count_q <= '0;
			end
			if (state_q == sps_pkg::ST_STEP && emit) begin
				if (more_steps) begin
					idx_q   <= idx_q + 3'd1;
					count_q <= count_q + 1'b1;
				end else begin
					old_q <= sample_q;
				end
			end
			if (emit) out_valid_q <= 1'b1;
			else if (pattern_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) sample_q <= position_sample;
		if (emit) begin
			pattern_q <= emit_pattern;
			last_q    <= emit_last;
		end
	end

	assign pattern_valid = out_valid_q;
	assign phase_pattern = pattern_q;
	assign last          = last_q;

	a_step_only_when_due: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.step |-> dstat.ge)
		else $error("distance stepped below divisor");

	a_no_tick_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> !tick_ready)
		else $error("tick taken before burst ended");

	a_dir_held_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sps_pkg::ST_STEP && $past(state_q) == sps_pkg::ST_STEP)
		|-> $stable(fwd_q))
		else $error("direction changed during burst");

endmodule

// ===== tb/stepper_phase_sequencer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_core_tb
// self-checking bench: ticks go in over a valid/ready channel, and every
// phase beat that comes out is matched against a local model of the mode,
// direction, phase index and held position, with random stalls on both sides
// ----------------------------------------------------------------------------
module stepper_phase_sequencer_core_tb;

	localparam int STEP_SCALE   = 32;
	localparam int STEP_DIVISOR = 1365;
	localparam int STEP_CAP     = 63;
	localparam int IDLE_PERCENT = 28;
	localparam int DRAIN_CYCLES = 80;
	localparam int PRINT_CAP    = 50;

	localparam logic [3:0] HALF_CW  [8] = '{4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9, 4'h8};
	localparam logic [3:0] HALF_CCW [8] = '{4'h8, 4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC};
	localparam logic [3:0] FULL_CW  [4] = '{4'hC, 4'h6, 4'h3, 4'h9};
	localparam logic [3:0] FULL_CCW [4] = '{4'h9, 4'h3, 4'h6, 4'hC};

	typedef struct packed {
		logic [3:0] pattern;
		logic       last;
	} coil_beat_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            tick_valid = 1'b0;
	logic                            tick_ready;
	logic [2:0]                      command = sps_pkg::CMD_NONE;
	logic [sps_pkg::SAMPLE_BITS-1:0] position_sample = '0;
	logic                            pattern_valid;
	logic                            pattern_ready = 1'b0;
	logic [3:0]                      phase_pattern;
	logic                            last;

	sps_pkg::mode_t                  drive_mode;
	logic                            drive_cw;
	logic [2:0]                      drive_idx;
	logic [sps_pkg::SAMPLE_BITS-1:0] held_position;

	coil_beat_t                      pending_beats[$];
	int                              mismatches = 0;
	bit                              stalls_on = 1'b1;
	logic [sps_pkg::SAMPLE_BITS-1:0] walk_position = '0;

	stepper_phase_sequencer_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.tick_valid      (tick_valid),
		.tick_ready      (tick_ready),
		.command         (command),
		.position_sample (position_sample),
		.pattern_valid   (pattern_valid),
		.pattern_ready   (pattern_ready),
		.phase_pattern   (phase_pattern),
		.last            (last)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	// works out the beats one accepted tick gives
	task automatic predict_tick(input logic [2:0] cmd,
			input logic [sps_pkg::SAMPLE_BITS-1:0] sample);
		logic                   neg;
		int                     span;
		int                     steps;
		coil_beat_t             b;
		case (cmd)
			sps_pkg::CMD_OFF: drive_mode = sps_pkg::MODE_OFF;
			sps_pkg::CMD_TOGGLE: drive_mode = (drive_mode == sps_pkg::MODE_CONT) ?
				sps_pkg::MODE_OFF : sps_pkg::MODE_CONT;
			sps_pkg::CMD_REVERSE: drive_cw = ~drive_cw;
			sps_pkg::CMD_FOLLOW: begin
				held_position = sample;
				drive_mode = sps_pkg::MODE_FOLLOW;
			end
			default: ;
		endcase
		if (drive_mode == sps_pkg::MODE_CONT) begin
			drive_idx = {1'b0, drive_idx[1:0] + 2'd1};
			b.pattern = drive_cw ? FULL_CW[drive_idx[1:0]] : FULL_CCW[drive_idx[1:0]];
			b.last = 1'b1;
			pending_beats.push_back(b);
		end else if (drive_mode == sps_pkg::MODE_FOLLOW) begin
			neg = sample < held_position;
			span = neg ? int'(held_position) - int'(sample) : int'(sample) - int'(held_position);
			steps = span * STEP_SCALE / STEP_DIVISOR;
			if (steps > STEP_CAP)
				steps = STEP_CAP;
			drive_cw = !(neg && steps > 0);
			for (int i = 0; i < steps; i++) begin
				drive_idx = drive_idx + 3'd1;
				b.pattern = drive_cw ? HALF_CW[drive_idx] : HALF_CCW[drive_idx];
				b.last = 1'b0;
				pending_beats.push_back(b);
			end
			held_position = sample;
			b.pattern = sps_pkg::PATTERN_RELEASED;
			b.last = 1'b1;
			pending_beats.push_back(b);
		end else begin
			b.pattern = sps_pkg::PATTERN_RELEASED;
			b.last = 1'b1;
			pending_beats.push_back(b);
		end
	endtask

	task automatic send_tick(input logic [2:0] cmd,
			input logic [sps_pkg::SAMPLE_BITS-1:0] sample);
		@(negedge clk);
		while (stalls_on && $urandom_range(99) < IDLE_PERCENT) begin
			tick_valid = 1'b0;
			@(negedge clk);
		end
		tick_valid = 1'b1;
		command = cmd;
		position_sample = sample;
		do
			@(posedge clk);
		while (!tick_ready);
		predict_tick(cmd, sample);
	endtask

	task automatic wait_for_beats;
		@(negedge clk);
		tick_valid = 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n)
			pattern_ready = 1'b0;
		else
			pattern_ready = stalls_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
	end

	always @(posedge clk) begin
		coil_beat_t want;
		if (arst_n && pattern_valid && pattern_ready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("unexpected beat, pattern", phase_pattern, 0);
			end else begin
				want = pending_beats.pop_front();
				if (phase_pattern !== want.pattern)
					report_mismatch("phase_pattern", phase_pattern, want.pattern);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end
	end

	// mode changes, direction and the unused command codes
	task automatic test_mode_commands;
		send_tick(sps_pkg::CMD_NONE, '0);
		send_tick(sps_pkg::CMD_NONE, '1);
		send_tick(sps_pkg::CMD_TOGGLE, 12'h555);
		send_tick(sps_pkg::CMD_NONE, 12'hAAA);
		send_tick(sps_pkg::CMD_NONE, '0);
		send_tick(sps_pkg::CMD_REVERSE, '1);
		send_tick(sps_pkg::CMD_NONE, '0);
		send_tick(sps_pkg::CMD_TOGGLE, '0);
		send_tick(sps_pkg::CMD_REVERSE, '0);
		for (int c = sps_pkg::CMD_FOLLOW + 1; c < 8; c++)
			send_tick(3'(c), '1);
		send_tick(sps_pkg::CMD_TOGGLE, '0);
		send_tick(sps_pkg::CMD_OFF, '0);
	endtask

	// zero distance, saturation both ways, the one-step edge and index wrap
	task automatic test_follow_distances;
		send_tick(sps_pkg::CMD_FOLLOW, '0);
		send_tick(sps_pkg::CMD_NONE, '1);
		send_tick(sps_pkg::CMD_NONE, '0);
		send_tick(sps_pkg::CMD_NONE, 12'd42);
		send_tick(sps_pkg::CMD_NONE, 12'd0);
		send_tick(sps_pkg::CMD_NONE, 12'd43);
		send_tick(sps_pkg::CMD_NONE, 12'd0);
		send_tick(sps_pkg::CMD_FOLLOW, 12'd2000);
		send_tick(sps_pkg::CMD_NONE, 12'd2300);
		send_tick(sps_pkg::CMD_TOGGLE, '0);
		send_tick(sps_pkg::CMD_NONE, '0);
		wait_for_beats();
	endtask

	function automatic logic [sps_pkg::SAMPLE_BITS-1:0] next_position();
		int p;
		if ($urandom_range(7) == 0)
			return sps_pkg::SAMPLE_BITS'($urandom);
		p = int'(walk_position) + int'($urandom_range(600)) - 300;
		if (p < 0)
			p = 0;
		if (p > (1 << sps_pkg::SAMPLE_BITS) - 1)
			p = (1 << sps_pkg::SAMPLE_BITS) - 1;
		return sps_pkg::SAMPLE_BITS'(p);
	endfunction

	function automatic logic [2:0] pick_command();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return sps_pkg::CMD_NONE;
		if (r < 69)
			return sps_pkg::CMD_OFF;
		if (r < 79)
			return sps_pkg::CMD_TOGGLE;
		if (r < 87)
			return sps_pkg::CMD_REVERSE;
		if (r < 96)
			return sps_pkg::CMD_FOLLOW;
		return 3'($urandom_range(7, sps_pkg::CMD_FOLLOW + 1));
	endfunction

	task automatic test_random_ticks(input int count);
		for (int i = 0; i < count; i++) begin
			walk_position = next_position();
			send_tick(pick_command(), walk_position);
			if (i == count / 2)
				wait_for_beats();
		end
	endtask

	task automatic test_back_to_back;
		stalls_on = 1'b0;
		send_tick(sps_pkg::CMD_TOGGLE, '0);
		for (int i = 0; i < 12; i++)
			send_tick(($urandom_range(3) == 0) ? sps_pkg::CMD_REVERSE : sps_pkg::CMD_NONE,
				sps_pkg::SAMPLE_BITS'($urandom));
		walk_position = sps_pkg::SAMPLE_BITS'($urandom);
		send_tick(sps_pkg::CMD_FOLLOW, walk_position);
		test_random_ticks(26);
		stalls_on = 1'b1;
	endtask

	initial begin
		drive_mode = sps_pkg::MODE_OFF;
		drive_cw = 1'b1;
		drive_idx = '0;
		held_position = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_mode_commands();
		test_follow_distances();
		test_random_ticks(160);
		test_back_to_back();

		wait_for_beats();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_beats.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== stepper_phase_sequencer_core.f =====
hw/rtl/sps_pkg.sv
hw/rtl/sps_dist_unit.sv
hw/rtl/stepper_phase_sequencer_core.sv
tb/stepper_phase_sequencer_core_tb.sv
